[sv/paa_pkg.sv]
package paa_pkg;

  // field widths fixed by the item formats
  localparam int unsigned BytesW = 24;
  localparam int unsigned PageW  = 6;
  localparam int unsigned PadW   = 3;

  // operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // status codes
  localparam logic ST_DONE       = 1'b0;
  localparam logic ST_TABLE_FULL = 1'b1;

  typedef struct packed {
    logic              operation;
    logic              pool;
    logic [BytesW-1:0] request_bytes;
  } alloc_req_t;

  typedef struct packed {
    logic              status;
    logic [PageW-1:0]  page_index;
    logic [BytesW-1:0] byte_offset;
    logic              opened_page;
    logic [BytesW-1:0] opened_page_bytes;
    logic [PadW-1:0]   padding;
  } alloc_rsp_t;

  // bytes to skip so a block of this size starts aligned after offset
  function automatic logic [PadW-1:0] align_pad(logic [BytesW-1:0] size,
                                                logic [PadW-1:0] low_bits);
    logic [PadW-1:0] mask;
    begin
      if (size == BytesW'(2)) begin
        mask = 3'd1;
      end else if (size >= BytesW'(4) && size < BytesW'(8)) begin
        mask = 3'd3;
      end else if (size >= BytesW'(8)) begin
        mask = 3'd7;
      end else begin
        mask = 3'd0;
      end
      align_pad = (3'd0 - (low_bits & mask)) & mask;
    end
  endfunction

endpackage

[sv/paged_arena_allocator_top.sv]
// path from input transfer to out_valid: release via S_DONE; oversize or empty pool via S_NEW,
// then S_DONE; else a first-fit scan of the N pages open in the pool (at most MAX_PAGES) via
// S_SCAN, then S_HIT or S_NEW, then S_DONE; one item at a time, one page entry read per cycle in S_SCAN;
// the next input is taken only after S_DONE, which waits on out_stall, hands on the result
// reset: synchronous active-high, page counts of both pools cleared, page_bytes set to 4096;
// page memories are not cleared, entries are used only after they are written
module paged_arena_allocator_top
  import paa_pkg::*;
#(
  parameter int unsigned MAX_PAGES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  alloc_req_t        in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output alloc_rsp_t        out_item,
  input  logic              cfg_we,
  input  logic [BytesW-1:0] cfg_wdata
);

  localparam int unsigned IW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CW    = $clog2(MAX_PAGES + 1);
  localparam int unsigned AW    = $clog2(2 * MAX_PAGES);
  localparam int unsigned Depth = 2 * MAX_PAGES;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_HIT  = 5'b00100,
    S_NEW  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  // configuration and per-pool page counts
  logic [BytesW-1:0] page_bytes;
  logic [CW-1:0]     pool_count [2];

  // page memories
  logic [BytesW-1:0] page_fill [Depth];
  logic [BytesW-1:0] page_free [Depth];
  logic [BytesW-1:0] rd_fill;
  logic [BytesW-1:0] rd_free;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;
  logic [BytesW-1:0] wr_fill;
  logic [BytesW-1:0] wr_free;

  // latched item and scan control
  logic              pool;
  logic [BytesW-1:0] size;
  logic [CW-1:0]     count;
  logic [IW-1:0]     scan_idx;
  logic [IW-1:0]     chk_idx;
  logic              chk_valid;

  // hit candidate
  logic [IW-1:0]     hit_idx;
  logic [BytesW-1:0] hit_fill;
  logic [BytesW-1:0] hit_free;
  logic [PadW-1:0]   hit_pad;

  alloc_rsp_t        res;

  // fit check on the entry just read
  logic [PadW-1:0]   chk_pad;
  logic [BytesW:0]   chk_need;
  logic              chk_fit;
  logic              chk_last;

  // new page capacity, oversize check and hit byte need
  logic [BytesW-1:0] new_cap;
  logic              oversize;
  logic [BytesW:0]   hit_need;

  function automatic logic [AW-1:0] entry_addr(logic p, logic [IW-1:0] idx);
    begin
      entry_addr = p ? (AW'(MAX_PAGES) + AW'(idx)) : AW'(idx);
    end
  endfunction

  assign in_stall = (state != S_IDLE);
  assign oversize = (in_item.request_bytes > page_bytes);

  assign chk_pad  = align_pad(size, rd_fill[PadW-1:0]);
  assign chk_need = {1'b0, size} + (BytesW+1)'(chk_pad);
  assign chk_fit  = ({1'b0, rd_free} >= chk_need);
  assign chk_last = ((CW'(chk_idx) + CW'(1)) == count);

  assign new_cap  = (size > page_bytes) ? size : page_bytes;
  assign hit_need = {1'b0, size} + (BytesW+1)'(hit_pad);

  assign rd_addr = entry_addr(pool, scan_idx);

  // memory write source
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = entry_addr(pool, hit_idx);
    wr_fill = hit_fill + hit_need[BytesW-1:0];
    wr_free = hit_free - hit_need[BytesW-1:0];
    if (state == S_HIT) begin
      wr_en = 1'b1;
    end else if (state == S_NEW && count < CW'(MAX_PAGES)) begin
      wr_en   = 1'b1;
      wr_addr = entry_addr(pool, IW'(count));
      wr_fill = size;
      wr_free = new_cap - size;
    end
  end

  // page memories, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      page_fill[wr_addr] <= wr_fill;
      page_free[wr_addr] <= wr_free;
    end
    rd_fill <= page_fill[rd_addr];
    rd_free <= page_free[rd_addr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes <= BytesW'(4096);
    end else if (cfg_we) begin
      page_bytes <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pool_count[0] <= '0;
      pool_count[1] <= '0;
      chk_valid     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // output register: load a finished result or retire the one taken
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pool      <= in_item.pool;
            size      <= in_item.request_bytes;
            count     <= pool_count[in_item.pool];
            scan_idx  <= '0;
            chk_valid <= 1'b0;
            res       <= '0;
            if (in_item.operation == OP_RELEASE) begin
              pool_count[in_item.pool] <= '0;
              state <= S_DONE;
            end else if (!oversize && pool_count[in_item.pool] != '0) begin
              state <= S_SCAN;
            end else begin
              state <= S_NEW;
            end
          end
        end
        S_SCAN: begin
          scan_idx  <= scan_idx + IW'(1);
          chk_idx   <= scan_idx;
          chk_valid <= 1'b1;
          if (chk_valid) begin
            if (chk_fit) begin
              hit_idx  <= chk_idx;
              hit_fill <= rd_fill;
              hit_free <= rd_free;
              hit_pad  <= chk_pad;
              state    <= S_HIT;
            end else if (chk_last) begin
              state <= S_NEW;
            end
          end
        end
        S_HIT: begin
          res.status      <= ST_DONE;
          res.page_index  <= PageW'(hit_idx);
          res.byte_offset <= hit_fill + BytesW'(hit_pad);
          res.padding     <= hit_pad;
          state           <= S_DONE;
        end
        S_NEW: begin
          if (count >= CW'(MAX_PAGES)) begin
            res.status <= ST_TABLE_FULL;
          end else begin
            pool_count[pool]      <= count + CW'(1);
            res.status            <= ST_DONE;
            res.page_index        <= PageW'(count);
            res.opened_page       <= 1'b1;
            res.opened_page_bytes <= new_cap;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // hand the result to the output register once it is free
          if (!out_valid || !out_stall) begin
            out_item <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
